>>> hdl/kpd_pkg.sv
// Shared types, state codes and keypad map for the keypad scanner.
`timescale 1ns / 1ps
package kpd_pkg;

	// scan phase codes
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_WAIT   = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// request kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [1:0]  ROW_TOP        = 2'd3;
	localparam logic [15:0] WAIT_MAX       = 16'hFFFF;

	typedef struct packed {
		logic       req_type;
		logic [3:0] col_levels;
	} req_t;

	typedef struct packed {
		logic [3:0]  row_drive;
		logic        key_valid;
		logic [6:0]  key_char;
		logic [15:0] fresh_keys;
	} res_t;

	// ASCII for each key bit, bit 0 first
	function automatic logic [6:0] key_ascii(input logic [3:0] idx);
		logic [6:0] ch;
		unique case (idx)
			4'd0:  ch = 7'h2A; // '*'
			4'd1:  ch = 7'h30; // '0'
			4'd2:  ch = 7'h23; // '#'
			4'd3:  ch = 7'h44; // 'D'
			4'd4:  ch = 7'h37; // '7'
			4'd5:  ch = 7'h38; // '8'
			4'd6:  ch = 7'h39; // '9'
			4'd7:  ch = 7'h43; // 'C'
			4'd8:  ch = 7'h34; // '4'
			4'd9:  ch = 7'h35; // '5'
			4'd10: ch = 7'h36; // '6'
			4'd11: ch = 7'h42; // 'B'
			4'd12: ch = 7'h31; // '1'
			4'd13: ch = 7'h32; // '2'
			4'd14: ch = 7'h33; // '3'
			default: ch = 7'h41; // 'A'
		endcase
		return ch;
	endfunction

endpackage

>>> hdl/kpd_key_enc.sv
// Lowest-set-bit key encoder: new-key mask to ASCII.
`timescale 1ns / 1ps
module kpd_key_enc (
	input  logic [15:0] mask,
	output logic [6:0]  key_char
);

	logic [15:0] lowest;

	// isolate lowest set bit
	assign lowest = mask & (~mask + 16'd1);

	always_comb begin
		key_char = '0;
		for (int i = 0; i < 16; i++) begin
			if (lowest[i]) begin
				key_char = key_char | kpd_pkg::key_ascii(4'(i));
			end
		end
	end

endmodule

>>> hdl/kpd_scan_fsm.sv
// Scan sequencer: row stepping, debounce wait, scan compare and stable set.
`timescale 1ns / 1ps
module kpd_scan_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  kpd_pkg::req_t      item,
	input  logic [15:0]        debounce_ticks,
	output kpd_pkg::res_t      result
);

	logic [1:0]  row_q, row_d;
	logic [1:0]  phase_q, phase_d;
	logic [15:0] accum_q, accum_d;
	logic [15:0] first_q, first_d;
	logic [15:0] stable_q, stable_d;
	logic [15:0] wait_q, wait_d;

	logic [15:0] shifted;
	logic [15:0] both;
	logic [15:0] fresh;
	logic [6:0]  ch;

	assign shifted = {accum_q[11:0], ~item.col_levels};
	assign both    = first_q & shifted;

	always_comb begin
		row_d    = row_q;
		phase_d  = phase_q;
		accum_d  = accum_q;
		first_d  = first_q;
		stable_d = stable_q;
		wait_d   = wait_q;
		fresh    = '0;
		if (phase_q == kpd_pkg::PH_WAIT) begin
			if (item.req_type == kpd_pkg::REQ_TICK) begin
				if (wait_q != kpd_pkg::WAIT_MAX) begin
					wait_d = wait_q + 16'd1;
				end
				if (wait_d >= debounce_ticks) begin
					phase_d = kpd_pkg::PH_SECOND;
					row_d   = kpd_pkg::ROW_TOP;
					accum_d = '0;
				end
			end
		end else if (item.req_type == kpd_pkg::REQ_SAMPLE) begin
			accum_d = shifted;
			if (row_q != 2'd0) begin
				row_d = row_q - 2'd1;
			end else if (phase_q == kpd_pkg::PH_SECOND) begin
				fresh    = both & ~stable_q;
				stable_d = both;
				phase_d  = kpd_pkg::PH_FIRST;
				row_d    = kpd_pkg::ROW_TOP;
				accum_d  = '0;
			end else begin
				first_d = shifted;
				accum_d = '0;
				row_d   = kpd_pkg::ROW_TOP;
				wait_d  = '0;
				phase_d = (debounce_ticks == 16'd0) ? kpd_pkg::PH_SECOND : kpd_pkg::PH_WAIT;
			end
		end
	end

	kpd_key_enc u_enc (
		.mask     (fresh),
		.key_char (ch)
	);

	always_comb begin
		result.row_drive  = ~(4'b0001 << row_d);
		result.key_valid  = (fresh != 16'd0);
		result.key_char   = ch;
		result.fresh_keys = fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= kpd_pkg::ROW_TOP;
			phase_q  <= kpd_pkg::PH_FIRST;
			accum_q  <= '0;
			first_q  <= '0;
			stable_q <= '0;
			wait_q   <= '0;
		end else if (advance) begin
			row_q    <= row_d;
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			first_q  <= first_d;
			stable_q <= stable_d;
			wait_q   <= wait_d;
		end
	end

endmodule

>>> hdl/keypad_scan_debounce_encoder.sv
// Top level of the 4x4 keypad scanner with debounce and ASCII encoding.
`timescale 1ns / 1ps
//
//  channel | signals                      | dir | beat
//  --------+------------------------------+-----+-------------------------------
//  req     | req_valid, req_stall, req    | in  | tick or column sample
//  res     | res_valid, res_stall, res    | out | row drive, key flag/char/mask
//  cfg     | cfg_we, cfg_data             | in  | debounce_ticks write
//
//  One result beat per request beat, one beat per cycle sustained while res is not stalled.
//  A beat passes the input register (s1), then the scan logic writes
//  the result register (s2). State updates when the s1 beat moves to s2.
//  A stall on res holds s2; s1 keeps one more beat before req_stall rises.
//  arst_n clears all control state; debounce_ticks resets to 20.
//
module keypad_scan_debounce_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  kpd_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output kpd_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data
);

	logic          valid_s1;
	kpd_pkg::req_t req_s1;
	logic          valid_s2;
	kpd_pkg::res_t res_s2;
	logic [15:0]   ticks_q;

	logic          s2_free;
	logic          advance;
	logic          req_take;
	kpd_pkg::res_t result;

	// s2 can take a beat when empty or being drained this cycle
	assign s2_free   = !valid_s2 || !res_stall;
	assign advance   = valid_s1 && s2_free;
	// s1 can take a beat when empty or moving on
	assign req_stall = valid_s1 && !s2_free;
	assign req_take  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= kpd_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	kpd_scan_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.item           (req_s1),
		.debounce_ticks (ticks_q),
		.result         (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// key flag, char and mask agree
	a_valid_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.key_valid == (res.fresh_keys != 16'd0)))
		else $error("key_valid disagrees with fresh_keys");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.key_valid) |-> (res.key_char == 7'd0))
		else $error("key_char set without a new key");

	// exactly one row driven low
	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot(~res.row_drive))
		else $error("row_drive not one-cold");

	// a stalled result beat holds in s2
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("result changed under stall");

endmodule
